// File: hdl/mbrtu_pkg.sv
// Shared types, constants and helpers of the Modbus RTU request and reply checker.
package mbrtu_pkg;

   localparam int RX_DEPTH = 32;
   localparam int IDX_W = $clog2(RX_DEPTH);
   localparam int LEN_W = 6;
   localparam int CMP_W = ((IDX_W > LEN_W) ? IDX_W : LEN_W) + 1;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;
   localparam logic [13:0] TIMER_HOLD = 14'd10000;
   localparam logic [4:0] DROP_MAX = 5'h1f;

   localparam logic [1:0] KIND_SEND = 2'd0;
   localparam logic [1:0] KIND_RX = 2'd1;
   localparam logic [1:0] KIND_TICK = 2'd2;
   localparam logic [1:0] KIND_NOP = 2'd3;

   localparam logic [1:0] STAT_BYTE = 2'd0;
   localparam logic [1:0] STAT_NONE = 2'd1;
   localparam logic [1:0] STAT_ACCEPT = 2'd2;
   localparam logic [1:0] STAT_TIMEOUT = 2'd3;

   localparam logic [7:0] FC_READ_HOLD = 8'h03;
   localparam logic [7:0] FC_READ_INPUT = 8'h04;
   localparam logic [7:0] FC_WRITE_ONE = 8'h06;
   localparam logic [7:0] FC_WRITE_MULTI = 8'h10;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] function_code;
      logic [7:0] node_addr;
      logic [15:0] start_reg;
      logic [3:0] reg_count;
      logic [15:0] write_value;
      logic [13:0] ack_ticks;
      logic [7:0] rx_byte;
   } req_item_type;

   typedef struct packed {
      logic [1:0] status;
      logic [7:0] tx_byte;
      logic last;
      logic [5:0] frame_length;
      logic [4:0] dropped_count;
   } rsp_item_type;

   typedef struct packed {
      logic clear;
      logic start;
      logic [7:0] data;
   } crc_ctl_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_TX_BYTE,
      S_TX_CRC,
      S_TX_PUT,
      S_CHK_LOOP,
      S_CHK_RD,
      S_CHK_USE,
      S_CHK_CRC,
      S_PUT
   } state_type;

   // circular buffer add, b below RX_DEPTH
   function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] a,
                                                 input logic [IDX_W-1:0] b);
      logic [IDX_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= (IDX_W+1)'(RX_DEPTH)) begin
         s = s - (IDX_W+1)'(RX_DEPTH);
      end
      return s[IDX_W-1:0];
   endfunction

endpackage

// File: hdl/mbrtu_crc.sv
// Bit-serial CRC-16 (reflected 0xA001), one data bit per cycle.
module mbrtu_crc (
   input  logic clock,
   input  logic reset,
   input  mbrtu_pkg::crc_ctl_type ctl,
   output logic busy,
   output logic [15:0] crc
);

   logic [15:0] crc_ff, crc_in;
   logic [7:0] sh_ff, sh_in;
   logic [3:0] cnt_ff, cnt_in;
   logic fb;

   always_comb begin
      crc_in = crc_ff;
      sh_in = sh_ff;
      cnt_in = cnt_ff;
      fb = crc_ff[0] ^ sh_ff[0];
      if (ctl.clear) begin
         crc_in = mbrtu_pkg::CRC_INIT;
      end else if (cnt_ff != 4'd0) begin
         crc_in = (crc_ff >> 1) ^ (fb ? mbrtu_pkg::CRC_POLY : 16'h0000);
         sh_in = sh_ff >> 1;
         cnt_in = cnt_ff - 4'd1;
      end else if (ctl.start) begin
         sh_in = ctl.data;
         cnt_in = 4'd8;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 4'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
      crc_ff <= crc_in;
      sh_ff <= sh_in;
   end

   assign busy = (cnt_ff != 4'd0);
   assign crc = crc_ff;

endmodule

// File: hdl/mbrtu_rxbuf.sv
// Receive byte store: one write port, one registered read port.
module mbrtu_rxbuf (
   input  logic clock,
   input  logic wr_en,
   input  logic [mbrtu_pkg::IDX_W-1:0] wr_addr,
   input  logic [7:0] wr_data,
   input  logic [mbrtu_pkg::IDX_W-1:0] rd_addr,
   output logic [7:0] rd_data
);

   logic [7:0] mem [mbrtu_pkg::RX_DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/modbus_rtu_request_and_reply_check.sv
// Modbus RTU master: request framing, reply search and tick timeout.
// One item at a time. A send item emits 6 or 8 request bytes; each data byte
// passes the byte state, the bit-serial CRC unit and the output state, and
// each CRC byte only the byte and output states. A tick, and a received byte
// when no check runs, go from idle to the put state; while waiting, each
// reply candidate at the buffer front starts in the loop state, each byte
// under the CRC is read, used and shifted through the CRC unit, each CRC byte
// is read and used, and this repeats once per dropped leading byte. Results
// leave through an output register that frees the sequencer while a result
// waits to be taken.
module modbus_rtu_request_and_reply_check (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  mbrtu_pkg::req_item_type req_item,
   output logic rsp_valid,
   input  logic rsp_stall,
   output mbrtu_pkg::rsp_item_type rsp_item
);

   localparam int IW = mbrtu_pkg::IDX_W;
   localparam int CW = mbrtu_pkg::CMP_W;

   mbrtu_pkg::state_type state_ff, state_in;
   mbrtu_pkg::req_item_type req_ff, req_in;
   mbrtu_pkg::rsp_item_type out_ff, out_in, res_ff, res_in;
   mbrtu_pkg::crc_ctl_type crc_ctl;
   logic out_valid_ff, out_valid_in;
   logic [7:0] exp_addr_ff, exp_addr_in, exp_code_ff, exp_code_in;
   logic [4:0] exp_edb_ff, exp_edb_in;
   logic [IW-1:0] fill_ff, fill_in, head_ff, head_in;
   logic waiting_ff, waiting_in;
   logic [13:0] timer_ff, timer_in;
   logic [2:0] idx_ff, idx_in;
   logic long_ff, long_in;
   logic [5:0] len_ff, len_in, pos_ff, pos_in;
   logic [4:0] drop_ff, drop_in;
   logic match_ff, match_in;
   logic [7:0] lo_ff, lo_in;
   logic crc_busy;
   logic [15:0] crc_val;
   logic [7:0] rd_data, tx_byte;
   logic [IW-1:0] rd_addr;
   logic wr_en, out_free, is_count, accept;
   logic [13:0] timer_dec;

   mbrtu_crc u_crc (
      .clock(clock), .reset(reset), .ctl(crc_ctl), .busy(crc_busy), .crc(crc_val)
   );

   mbrtu_rxbuf u_rxbuf (
      .clock(clock), .wr_en(wr_en), .wr_addr(mbrtu_pkg::wrap_add(head_ff, fill_ff)),
      .wr_data(req_item.rx_byte), .rd_addr(rd_addr), .rd_data(rd_data)
   );

   assign accept = req_valid && !req_stall;
   assign out_free = !out_valid_ff || !rsp_stall;
   assign is_count = (req_ff.function_code == mbrtu_pkg::FC_READ_HOLD) ||
                     (req_ff.function_code == mbrtu_pkg::FC_READ_INPUT);
   assign rd_addr = mbrtu_pkg::wrap_add(head_ff, IW'(pos_ff));
   assign timer_dec = (timer_ff != 14'd0) ? timer_ff - 14'd1 : timer_ff;

   always_comb begin
      case (idx_ff)
         3'd0: tx_byte = req_ff.node_addr;
         3'd1: tx_byte = req_ff.function_code;
         3'd2: tx_byte = req_ff.start_reg[15:8];
         3'd3: tx_byte = req_ff.start_reg[7:0];
         3'd4: tx_byte = !long_ff ? crc_val[7:0] :
                         (is_count ? 8'h00 : req_ff.write_value[15:8]);
         3'd5: tx_byte = !long_ff ? crc_val[15:8] :
                         (is_count ? {4'h0, req_ff.reg_count} : req_ff.write_value[7:0]);
         3'd6: tx_byte = crc_val[7:0];
         default: tx_byte = crc_val[15:8];
      endcase
   end

   always_comb begin
      state_in = state_ff;
      req_in = req_ff;
      res_in = res_ff;
      out_in = out_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      exp_addr_in = exp_addr_ff;
      exp_code_in = exp_code_ff;
      exp_edb_in = exp_edb_ff;
      fill_in = fill_ff;
      head_in = head_ff;
      waiting_in = waiting_ff;
      timer_in = timer_ff;
      idx_in = idx_ff;
      long_in = long_ff;
      len_in = len_ff;
      pos_in = pos_ff;
      drop_in = drop_ff;
      match_in = match_ff;
      lo_in = lo_ff;
      crc_ctl = '0;
      wr_en = 1'b0;
      req_stall = (state_ff != mbrtu_pkg::S_IDLE);
      unique case (state_ff)
         mbrtu_pkg::S_IDLE: begin
            res_in = '0;
            res_in.status = mbrtu_pkg::STAT_NONE;
            res_in.last = 1'b1;
            if (accept) begin
               req_in = req_item;
               unique case (req_item.kind)
                  mbrtu_pkg::KIND_SEND: begin
                     exp_addr_in = req_item.node_addr;
                     exp_code_in = req_item.function_code;
                     if ((req_item.function_code == mbrtu_pkg::FC_READ_HOLD) ||
                         (req_item.function_code == mbrtu_pkg::FC_READ_INPUT)) begin
                        exp_edb_in = {req_item.reg_count, 1'b1};
                        long_in = 1'b1;
                     end else if ((req_item.function_code == mbrtu_pkg::FC_WRITE_ONE) ||
                                  (req_item.function_code == mbrtu_pkg::FC_WRITE_MULTI)) begin
                        exp_edb_in = 5'd4;
                        long_in = 1'b1;
                     end else begin
                        long_in = 1'b0;
                     end
                     fill_in = '0;
                     waiting_in = 1'b1;
                     timer_in = req_item.ack_ticks;
                     idx_in = 3'd0;
                     crc_ctl.clear = 1'b1;
                     state_in = mbrtu_pkg::S_TX_BYTE;
                  end
                  mbrtu_pkg::KIND_RX: begin
                     wr_en = 1'b1;
                     fill_in = (fill_ff == IW'(mbrtu_pkg::RX_DEPTH - 1)) ? '0 : fill_ff + 1'b1;
                     drop_in = '0;
                     len_in = {1'b0, exp_edb_ff} + 6'd4;
                     if (waiting_ff && (timer_ff <= mbrtu_pkg::TIMER_HOLD)) begin
                        state_in = mbrtu_pkg::S_CHK_LOOP;
                     end else begin
                        state_in = mbrtu_pkg::S_PUT;
                     end
                  end
                  mbrtu_pkg::KIND_TICK: begin
                     timer_in = timer_dec;
                     if (waiting_ff && (timer_dec == 14'd0)) begin
                        waiting_in = 1'b0;
                        res_in.status = mbrtu_pkg::STAT_TIMEOUT;
                     end
                     state_in = mbrtu_pkg::S_PUT;
                  end
                  default: state_in = mbrtu_pkg::S_PUT;
               endcase
            end
         end
         mbrtu_pkg::S_TX_BYTE: begin
            if (idx_ff < (long_ff ? 3'd6 : 3'd4)) begin
               crc_ctl.start = 1'b1;
               crc_ctl.data = tx_byte;
               state_in = mbrtu_pkg::S_TX_CRC;
            end else begin
               state_in = mbrtu_pkg::S_TX_PUT;
            end
         end
         mbrtu_pkg::S_TX_CRC: begin
            if (!crc_busy) begin
               state_in = mbrtu_pkg::S_TX_PUT;
            end
         end
         mbrtu_pkg::S_TX_PUT: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_in = '0;
               out_in.status = mbrtu_pkg::STAT_BYTE;
               out_in.tx_byte = tx_byte;
               out_in.last = (idx_ff == (long_ff ? 3'd7 : 3'd5));
               idx_in = idx_ff + 3'd1;
               state_in = out_in.last ? mbrtu_pkg::S_IDLE : mbrtu_pkg::S_TX_BYTE;
            end
         end
         mbrtu_pkg::S_CHK_LOOP: begin
            if (CW'(fill_ff) >= CW'(len_ff)) begin
               pos_in = '0;
               crc_ctl.clear = 1'b1;
               state_in = mbrtu_pkg::S_CHK_RD;
            end else begin
               res_in.dropped_count = drop_ff;
               state_in = mbrtu_pkg::S_PUT;
            end
         end
         mbrtu_pkg::S_CHK_RD: begin
            // read address issued here, data registered for the next state
            state_in = mbrtu_pkg::S_CHK_USE;
         end
         mbrtu_pkg::S_CHK_USE: begin
            if (pos_ff == 6'd0) begin
               match_in = (rd_data == exp_addr_ff);
            end else if (pos_ff == 6'd1) begin
               match_in = match_ff && (rd_data == exp_code_ff);
            end
            if (pos_ff < len_ff - 6'd2) begin
               crc_ctl.start = 1'b1;
               crc_ctl.data = rd_data;
               state_in = mbrtu_pkg::S_CHK_CRC;
            end else if (pos_ff == len_ff - 6'd2) begin
               lo_in = rd_data;
               pos_in = pos_ff + 6'd1;
               state_in = mbrtu_pkg::S_CHK_RD;
            end else if (match_ff && ({rd_data, lo_ff} == crc_val)) begin
               head_in = mbrtu_pkg::wrap_add(head_ff, IW'(len_ff));
               fill_in = IW'(CW'(fill_ff) - CW'(len_ff));
               waiting_in = 1'b0;
               res_in.status = mbrtu_pkg::STAT_ACCEPT;
               res_in.frame_length = len_ff;
               res_in.dropped_count = drop_ff;
               state_in = mbrtu_pkg::S_PUT;
            end else begin
               head_in = mbrtu_pkg::wrap_add(head_ff, IW'(1));
               fill_in = fill_ff - 1'b1;
               drop_in = (drop_ff == mbrtu_pkg::DROP_MAX) ? drop_ff : drop_ff + 5'd1;
               state_in = mbrtu_pkg::S_CHK_LOOP;
            end
         end
         mbrtu_pkg::S_CHK_CRC: begin
            if (!crc_busy) begin
               pos_in = pos_ff + 6'd1;
               state_in = mbrtu_pkg::S_CHK_RD;
            end
         end
         mbrtu_pkg::S_PUT: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_in = res_ff;
               state_in = mbrtu_pkg::S_IDLE;
            end
         end
         default: state_in = mbrtu_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mbrtu_pkg::S_IDLE;
         out_valid_ff <= 1'b0;
         exp_addr_ff <= '0;
         exp_code_ff <= '0;
         exp_edb_ff <= '0;
         fill_ff <= '0;
         head_ff <= '0;
         waiting_ff <= 1'b0;
         timer_ff <= '0;
      end else begin
         state_ff <= state_in;
         out_valid_ff <= out_valid_in;
         exp_addr_ff <= exp_addr_in;
         exp_code_ff <= exp_code_in;
         exp_edb_ff <= exp_edb_in;
         fill_ff <= fill_in;
         head_ff <= head_in;
         waiting_ff <= waiting_in;
         timer_ff <= timer_in;
      end
      req_ff <= req_in;
      res_ff <= res_in;
      out_ff <= out_in;
      idx_ff <= idx_in;
      long_ff <= long_in;
      len_ff <= len_in;
      pos_ff <= pos_in;
      drop_ff <= drop_in;
      match_ff <= match_in;
      lo_ff <= lo_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_item = out_ff;

`ifndef SYNTHESIS
   a_status_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_item.status != mbrtu_pkg::STAT_BYTE)) |-> rsp_item.last)
      else $error("single status item without last");
   a_accept_len: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_item.status == mbrtu_pkg::STAT_ACCEPT)) |->
      (rsp_item.frame_length >= 6'd4))
      else $error("accepted reply shorter than header and crc");
   a_fill_range: assert property (@(posedge clock) disable iff (reset)
      CW'(fill_ff) < CW'(mbrtu_pkg::RX_DEPTH))
      else $error("fill count out of range");
   a_accept_clears_wait: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mbrtu_pkg::S_CHK_USE && state_in == mbrtu_pkg::S_PUT) |=> !waiting_ff)
      else $error("wait flag still set after accepted reply");
`endif

endmodule

// File: tb/modbus_rtu_request_and_reply_check_checker.sv
`timescale 1ns / 1ps
// Checker for the Modbus RTU master: predicts request bytes and reply status per accepted item.
module modbus_rtu_request_and_reply_check_checker (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   input  logic req_stall,
   input  mbrtu_pkg::req_item_type req_item,
   input  logic rsp_valid,
   input  logic rsp_stall,
   input  mbrtu_pkg::rsp_item_type rsp_item,
   output int fail_count,
   output int pending_count
);

   logic [7:0] exp_addr;
   logic [7:0] exp_code;
   logic [4:0] exp_data_bytes;
   logic [7:0] rx_buf [0:mbrtu_pkg::RX_DEPTH-1];
   int unsigned rx_cnt;
   logic wait_reply;
   logic [13:0] timer;
   mbrtu_pkg::rsp_item_type expected_q[$];

   function automatic logic [15:0] crc_of(input logic [7:0] b [0:mbrtu_pkg::RX_DEPTH-1],
                                         input int n);
      logic [15:0] c;
      c = mbrtu_pkg::CRC_INIT;
      for (int i = 0; i < n; i++) begin
         c = c ^ {8'h00, b[i]};
         for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ mbrtu_pkg::CRC_POLY) : (c >> 1);
         end
      end
      return c;
   endfunction

   function automatic mbrtu_pkg::rsp_item_type mk(input logic [1:0] st, input logic [7:0] tx,
                                                  input logic lst, input logic [5:0] fl,
                                                  input logic [4:0] dr);
      mbrtu_pkg::rsp_item_type r;
      r.status = st;
      r.tx_byte = tx;
      r.last = lst;
      r.frame_length = fl;
      r.dropped_count = dr;
      return r;
   endfunction

   task automatic shift_out(input int n);
      for (int i = 0; i + n < int'(rx_cnt); i++) rx_buf[i] = rx_buf[i + n];
      rx_cnt = rx_cnt - n;
   endtask

   task automatic predict_item(input mbrtu_pkg::req_item_type it);
      logic [7:0] frame [0:mbrtu_pkg::RX_DEPTH-1];
      logic [15:0] crc;
      int n;
      int len;
      int dropped;
      bit ok;
      n = 0;
      dropped = 0;
      ok = 0;
      len = 0;
      if (it.kind == mbrtu_pkg::KIND_SEND) begin
         exp_addr = it.node_addr;
         exp_code = it.function_code;
         frame[0] = it.node_addr;
         frame[1] = it.function_code;
         frame[2] = it.start_reg[15:8];
         frame[3] = it.start_reg[7:0];
         n = 4;
         if (it.function_code == mbrtu_pkg::FC_READ_HOLD ||
             it.function_code == mbrtu_pkg::FC_READ_INPUT) begin
            frame[4] = 8'h00;
            frame[5] = {4'h0, it.reg_count};
            n = 6;
            exp_data_bytes = {it.reg_count, 1'b1};
         end else if (it.function_code == mbrtu_pkg::FC_WRITE_ONE ||
                      it.function_code == mbrtu_pkg::FC_WRITE_MULTI) begin
            frame[4] = it.write_value[15:8];
            frame[5] = it.write_value[7:0];
            n = 6;
            exp_data_bytes = 5'd4;
         end
         crc = crc_of(frame, n);
         frame[n] = crc[7:0];
         frame[n+1] = crc[15:8];
         n = n + 2;
         rx_cnt = 0;
         wait_reply = 1'b1;
         timer = it.ack_ticks;
         for (int i = 0; i < n; i++)
            expected_q.push_back(mk(mbrtu_pkg::STAT_BYTE, frame[i], i + 1 == n, 6'd0, 5'd0));
      end else if (it.kind == mbrtu_pkg::KIND_RX) begin
         rx_buf[rx_cnt % mbrtu_pkg::RX_DEPTH] = it.rx_byte;
         rx_cnt = (rx_cnt + 1) % mbrtu_pkg::RX_DEPTH;
         if (wait_reply && timer <= mbrtu_pkg::TIMER_HOLD) begin
            len = int'(exp_data_bytes) + 4;
            while (int'(rx_cnt) >= len && len <= mbrtu_pkg::RX_DEPTH) begin
               crc = crc_of(rx_buf, len - 2);
               if (rx_buf[0] == exp_addr && rx_buf[1] == exp_code &&
                   {rx_buf[len-1], rx_buf[len-2]} == crc) begin
                  ok = 1;
                  break;
               end
               shift_out(1);
               dropped++;
            end
         end
         if (dropped > 31) dropped = 31;
         if (ok) begin
            shift_out(len);
            wait_reply = 1'b0;
            expected_q.push_back(mk(mbrtu_pkg::STAT_ACCEPT, 8'd0, 1'b1, 6'(len),
                                    5'(dropped)));
         end else begin
            expected_q.push_back(mk(mbrtu_pkg::STAT_NONE, 8'd0, 1'b1, 6'd0, 5'(dropped)));
         end
      end else if (it.kind == mbrtu_pkg::KIND_TICK) begin
         if (timer != 14'd0) timer = timer - 14'd1;
         if (wait_reply && timer == 14'd0) begin
            wait_reply = 1'b0;
            expected_q.push_back(mk(mbrtu_pkg::STAT_TIMEOUT, 8'd0, 1'b1, 6'd0, 5'd0));
         end else begin
            expected_q.push_back(mk(mbrtu_pkg::STAT_NONE, 8'd0, 1'b1, 6'd0, 5'd0));
         end
      end else begin
         expected_q.push_back(mk(mbrtu_pkg::STAT_NONE, 8'd0, 1'b1, 6'd0, 5'd0));
      end
   endtask

   always @(posedge clock) begin
      mbrtu_pkg::rsp_item_type e;
      if (reset) begin
         exp_addr = '0;
         exp_code = '0;
         exp_data_bytes = '0;
         rx_cnt = 0;
         wait_reply = 1'b0;
         timer = '0;
         fail_count <= 0;
         expected_q.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_q.size() == 0) begin
               $error("result with nothing expected: %p", rsp_item);
               fail_count <= fail_count + 1;
            end else begin
               e = expected_q.pop_front();
               if (e != rsp_item) begin
                  if (e.status != rsp_item.status)
                     $error("status: expected %0d, got %0d", e.status, rsp_item.status);
                  if (e.tx_byte != rsp_item.tx_byte)
                     $error("tx_byte: expected %0h, got %0h", e.tx_byte, rsp_item.tx_byte);
                  if (e.last != rsp_item.last)
                     $error("last: expected %0d, got %0d", e.last, rsp_item.last);
                  if (e.frame_length != rsp_item.frame_length)
                     $error("frame_length: expected %0d, got %0d", e.frame_length,
                            rsp_item.frame_length);
                  if (e.dropped_count != rsp_item.dropped_count)
                     $error("dropped_count: expected %0d, got %0d", e.dropped_count,
                            rsp_item.dropped_count);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_valid && !req_stall) predict_item(req_item);
      end
      pending_count = expected_q.size();
   end

endmodule

// File: tb/tb_modbus_rtu_request_and_reply_check.sv
`timescale 1ns / 1ps
// Testbench top: request and reply stimulus for the Modbus RTU master, verdict at the end.
module tb_modbus_rtu_request_and_reply_check;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   mbrtu_pkg::req_item_type req_item = '0;
   logic rsp_valid;
   logic rsp_stall = 0;
   mbrtu_pkg::rsp_item_type rsp_item;
   int fail_count;
   int pending_count;
   bit rsp_hold_on = 1;

   // host-side copy of the last request, to build matching replies
   logic [7:0] host_addr;
   logic [7:0] host_code;
   logic [3:0] host_cnt;

   always begin
      #1 clock = 1;
      #1 clock = 0;
   end

   modbus_rtu_request_and_reply_check DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_item(req_item),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_item(rsp_item)
   );

   modbus_rtu_request_and_reply_check_checker checker_i (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_item(req_item),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_item(rsp_item),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   // receiver: random stall lengths, with quiet stretches
   initial begin
      int n;
      @(posedge clock iff !reset);
      forever begin
         n = ($urandom_range(0, 3) == 0 || !rsp_hold_on) ? 0 : $urandom_range(0, 18);
         if (n > 0) begin
            rsp_stall <= 1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 0;
         @(posedge clock iff rsp_valid);
      end
   end

   function automatic logic [15:0] frame_crc(input logic [7:0] b [0:31], input int n);
      logic [15:0] c;
      c = mbrtu_pkg::CRC_INIT;
      for (int i = 0; i < n; i++) begin
         c = c ^ {8'h00, b[i]};
         for (int k = 0; k < 8; k++) c = c[0] ? ((c >> 1) ^ mbrtu_pkg::CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

   task automatic push_item(input mbrtu_pkg::req_item_type it, input bit may_gap);
      int g;
      g = (may_gap && $urandom_range(0, 2) != 0) ? $urandom_range(0, 18) : 0;
      if (g > 0) begin
         req_valid <= 0;
         repeat (g) @(posedge clock);
      end
      req_item <= it;
      req_valid <= 1;
      @(posedge clock iff !req_stall);
      if (it.kind == mbrtu_pkg::KIND_SEND) begin
         host_addr = it.node_addr;
         host_code = it.function_code;
         host_cnt = it.reg_count;
      end
   endtask

   function automatic mbrtu_pkg::req_item_type rand_item();
      logic [95:0] r;
      r = {$urandom, $urandom, $urandom};
      return r[$bits(mbrtu_pkg::req_item_type)-1:0];
   endfunction

   task automatic do_send(input logic [7:0] code, input logic [7:0] addr,
                          input logic [13:0] ticks, input bit g);
      mbrtu_pkg::req_item_type it;
      it = rand_item();
      it.kind = mbrtu_pkg::KIND_SEND;
      it.function_code = code;
      it.node_addr = addr;
      it.ack_ticks = ticks;
      it.reg_count = 4'($urandom_range(0, 13));
      push_item(it, g);
   endtask

   task automatic do_rx(input logic [7:0] b, input bit g);
      mbrtu_pkg::req_item_type it;
      it = rand_item();
      it.kind = mbrtu_pkg::KIND_RX;
      it.rx_byte = b;
      push_item(it, g);
   endtask

   task automatic do_tick(input bit g);
      mbrtu_pkg::req_item_type it;
      it = rand_item();
      it.kind = mbrtu_pkg::KIND_TICK;
      push_item(it, g);
   endtask

   // send a well-formed reply, optionally with junk in front or a corrupt byte
   task automatic do_reply(input int junk, input bit corrupt, input bit g);
      logic [7:0] b [0:31];
      logic [15:0] c;
      int dlen;
      int n;
      if (host_code == mbrtu_pkg::FC_READ_HOLD || host_code == mbrtu_pkg::FC_READ_INPUT)
         dlen = 2 * host_cnt + 1;
      else
         dlen = 4;
      b[0] = host_addr;
      b[1] = host_code;
      for (int i = 0; i < dlen; i++) b[2 + i] = 8'($urandom);
      n = dlen + 2;
      c = frame_crc(b, n);
      b[n] = c[7:0];
      b[n+1] = c[15:8];
      n = n + 2;
      if (corrupt) b[$urandom_range(0, n - 1)] ^= 8'($urandom_range(1, 255));
      for (int i = 0; i < junk; i++) do_rx(8'($urandom), g);
      for (int i = 0; i < n; i++) do_rx(b[i], g);
   endtask

   function automatic logic [7:0] pick_code();
      case ($urandom_range(0, 5))
         0: return mbrtu_pkg::FC_READ_HOLD;
         1: return mbrtu_pkg::FC_READ_INPUT;
         2: return mbrtu_pkg::FC_WRITE_ONE;
         3: return mbrtu_pkg::FC_WRITE_MULTI;
         default: return 8'($urandom);
      endcase
   endfunction

   initial begin
      int cnt;
      int tmo;
      mbrtu_pkg::req_item_type it;
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: every code, extremes, timeout, replace, hold, not waiting, kind 3
      do_rx(8'h00, 0);
      do_tick(0);
      do_send(mbrtu_pkg::FC_READ_HOLD, 8'h00, 14'd100, 0);
      do_reply(0, 0, 0);
      do_send(mbrtu_pkg::FC_READ_INPUT, 8'hFF, 14'd10000, 0);
      do_reply(2, 0, 0);
      do_send(mbrtu_pkg::FC_WRITE_ONE, 8'h11, 14'd2, 0);
      do_tick(0);
      do_tick(0);
      do_tick(0);
      do_send(mbrtu_pkg::FC_WRITE_MULTI, 8'h22, 14'h3FFF, 0);
      do_reply(0, 0, 0);
      do_send(8'hFF, 8'h33, 14'd0, 0);
      do_tick(0);
      do_send(8'h00, 8'h44, 14'd50, 0);
      do_send(mbrtu_pkg::FC_WRITE_ONE, 8'h55, 14'd50, 0);
      do_reply(1, 1, 0);
      it = '1;
      it.kind = mbrtu_pkg::KIND_NOP;
      push_item(it, 0);
      it = '0;
      push_item(it, 0);

      // hold off until drained once
      req_valid <= 0;
      @(posedge clock iff pending_count == 0);

      cnt = 0;
      while (cnt < 360) begin
         rsp_hold_on = ($urandom_range(0, 7) != 0);
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: begin
               do_send(pick_code(), 8'($urandom),
                       ($urandom_range(0, 9) == 0) ? 14'($urandom) : 14'($urandom_range(0, 40)),
                       1);
               do_reply($urandom_range(0, 3) == 0 ? $urandom_range(1, 4) : 0,
                        $urandom_range(0, 4) == 0, 1);
               cnt += 12;
            end
            6: begin
               tmo = $urandom_range(1, 8);
               for (int i = 0; i < tmo; i++) do_tick(1);
               cnt += tmo;
            end
            7: begin
               for (int i = 0; i < 6; i++) do_rx(8'($urandom), 1);
               cnt += 6;
            end
            default: begin
               push_item(rand_item(), 1);
               cnt++;
            end
         endcase
      end
      req_valid <= 0;
      @(posedge clock iff pending_count == 0);
      repeat (400) @(posedge clock);
      if (fail_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   initial begin
      #20000000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
